>>> sv/dtws_pkg.sv
`default_nettype none
package dtws_pkg;

    localparam int ANGLE_FRAC_BITS = 14;
    localparam int SPEED_FRAC_BITS = 4;
    localparam int CSTEPS          = 24;
    localparam int XW              = 34;
    localparam int ZW              = 33;
    localparam int DIV_QW          = 21;
    localparam int BASE_W          = 17;

    localparam logic [19:0] SPEED_K_Q24    = 20'd951657;
    localparam longint      HALF_PI_Q30    = 64'd1686629713;
    localparam logic [14:0] HALF_PI_ANG    = 15'(HALF_PI_Q30 >> (30 - ANGLE_FRAC_BITS));
    localparam logic [19:0] RADIUS_MAX     = 20'hFFFFF;
    localparam logic [16:0] RATIO_ONE      = 17'd65536;

    typedef enum logic [1:0] {
        CFG_CAR_LENGTH  = 2'd0,
        CFG_TRACK_WIDTH = 2'd1,
        CFG_MAX_STEER   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                     vld;
        logic                     right;
        logic signed [BASE_W-1:0] base;
    } t_side;

    typedef struct packed {
        logic                     vld;
        logic                     right;
        logic signed [BASE_W-1:0] base;
        logic                     ysat;
        logic                     xz;
    } t_ctl;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] v;
        begin
            unique case (i)
                0:  v = 33'sd843314857;
                1:  v = 33'sd497837829;
                2:  v = 33'sd263043837;
                3:  v = 33'sd133525159;
                4:  v = 33'sd67021687;
                5:  v = 33'sd33543516;
                6:  v = 33'sd16775851;
                7:  v = 33'sd8388437;
                8:  v = 33'sd4194283;
                9:  v = 33'sd2097149;
                10: v = 33'sd1048576;
                default: v = ZW'(64'sd1 <<< (30 - i));
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/dtws_front.sv
`default_nettype none
module dtws_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_vld,
    input  wire logic signed [14:0]       i_a,
    input  wire logic signed [14:0]       i_b,
    input  wire logic [14:0]              i_ang,
    input  wire logic                     i_right,
    input  wire logic [14:0]              i_max_ang,
    output dtws_pkg::t_side               o_side,
    output logic signed [dtws_pkg::ZW-1:0] o_z
);
    import dtws_pkg::*;

    localparam int PW = 37;
    localparam int MW = PW + SPEED_FRAC_BITS + 1;

    logic                 r1_vld, r2_vld, r3_vld;
    logic                 r1_right, r2_right, r3_right;
    logic signed [15:0]   r1_diff;
    logic [14:0]          r1_ang;
    logic signed [PW-1:0] r2_prod;
    logic signed [ZW-1:0] r2_z, r3_z;
    logic signed [BASE_W-1:0] r3_base;

    logic [14:0]          n_ang;
    logic [PW-1:0]        mag;
    logic [MW-1:0]        rnd;
    logic [BASE_W-1:0]    bmag;
    logic signed [BASE_W-1:0] n_base;

    always_comb begin
        n_ang = i_ang;
        if (n_ang > i_max_ang) n_ang = i_max_ang;
        if (n_ang > HALF_PI_ANG) n_ang = HALF_PI_ANG;
        mag  = r2_prod[PW-1] ? PW'(-r2_prod) : PW'(r2_prod);
        rnd  = (MW'(mag) << SPEED_FRAC_BITS) + (MW'(1) << 23);
        bmag = BASE_W'(rnd >> 24);
        n_base = r2_prod[PW-1] ? -$signed(bmag) : $signed(bmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        if (i_en) begin
            r1_diff  <= 16'(signed'({i_b[14], i_b}) - signed'({i_a[14], i_a}));
            r1_ang   <= n_ang;
            r1_right <= i_right;
            r2_prod  <= PW'(r1_diff * $signed({1'b0, SPEED_K_Q24}));
            r2_z     <= $signed(ZW'({r1_ang, (30 - ANGLE_FRAC_BITS)'(0)}));
            r2_right <= r1_right;
            r3_base  <= n_base;
            r3_z     <= r2_z;
            r3_right <= r2_right;
        end
    end

    assign o_side = '{vld: r3_vld, right: r3_right, base: r3_base};
    assign o_z    = r3_z;

endmodule
`default_nettype wire

>>> sv/dtws_cordic.sv
`default_nettype none
module dtws_cordic (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic signed [dtws_pkg::ZW-1:0] i_z,
    input  wire dtws_pkg::t_side           i_side,
    output logic signed [dtws_pkg::XW-1:0] o_x,
    output logic signed [dtws_pkg::XW-1:0] o_y,
    output dtws_pkg::t_side                o_side
);
    import dtws_pkg::*;

    logic signed [XW-1:0] r_x [1:CSTEPS];
    logic signed [XW-1:0] r_y [1:CSTEPS];
    logic signed [ZW-1:0] r_z [1:CSTEPS];
    t_side                r_s [1:CSTEPS];

    for (genvar i = 0; i < CSTEPS; i++) begin : g_step
        logic signed [XW-1:0] px, py;
        logic signed [ZW-1:0] pz;
        t_side                ps;
        if (i == 0) begin : g_first
            assign px = XW'(64'sd1 <<< 30);
            assign py = '0;
            assign pz = i_z;
            assign ps = i_side;
        end else begin : g_next
            assign px = r_x[i];
            assign py = r_y[i];
            assign pz = r_z[i];
            assign ps = r_s[i];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s[i+1].vld <= 1'b0;
            end else if (i_en) begin
                if (pz >= 0) begin
                    r_x[i+1] <= px - (py >>> i);
                    r_y[i+1] <= py + (px >>> i);
                    r_z[i+1] <= pz - atan_q30(i);
                end else begin
                    r_x[i+1] <= px + (py >>> i);
                    r_y[i+1] <= py - (px >>> i);
                    r_z[i+1] <= pz + atan_q30(i);
                end
                r_s[i+1] <= ps;
            end
        end
    end

    assign o_x    = r_x[CSTEPS];
    assign o_y    = r_y[CSTEPS];
    assign o_side = r_s[CSTEPS];

endmodule
`default_nettype wire

>>> sv/dtws_div.sv
`default_nettype none
module dtws_div #(
    parameter int NW = 47,
    parameter int DW = 32,
    parameter int QW = 21
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_n,
    input  wire logic [DW-1:0] i_d,
    output logic [QW-1:0]      o_q,
    output logic               o_ovf
);
    localparam int CW = NW + DW;

    logic [DW-1:0] r_r   [0:QW];
    logic [QW-1:0] r_nl  [0:QW];
    logic [DW-1:0] r_d   [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_ovf [0:QW];
    logic [CW-1:0] hi;

    assign hi = CW'(i_n >> QW);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]   <= hi[DW-1:0];
            r_nl[0]  <= i_n[QW-1:0];
            r_d[0]   <= i_d;
            r_q[0]   <= '0;
            r_ovf[0] <= hi >= CW'(i_d);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        logic [DW:0] t;
        logic        ge;
        assign t  = {r_r[k], r_nl[k][QW-1-k]};
        assign ge = t >= {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k+1]   <= ge ? DW'(t - {1'b0, r_d[k]}) : t[DW-1:0];
                r_nl[k+1]  <= r_nl[k];
                r_d[k+1]   <= r_d[k];
                r_q[k+1]   <= {r_q[k][QW-2:0], ge};
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];

endmodule
`default_nettype wire

>>> sv/differential_turn_wheel_speeds.sv
// Differential-drive wheel speed block. Each transfer carries two motor shaft
// speeds, a steering angle (Q1.14 rad) and a turn direction; one result comes
// back per transfer with left and right wheel speeds (1/16 mm/s), the turn
// radius (1/16 mm) and a saturation flag. The pipeline takes one transfer per
// clock while the output is not stalled; its stages are 3 of base speed and
// angle clamp, a 24-stage CORDIC, one multiply stage, two 22-stage dividers
// side by side, and 3 stages of wheel speed scaling. The pipeline advances
// as a whole whenever the output register is empty or being taken. Write the
// three registers through the configuration channel only while no transfer
// is in flight; indexes past the last register are ignored.
`default_nettype none
module differential_turn_wheel_speeds (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [14:0] i_motor_a_rpm,
    input  wire logic signed [14:0] i_motor_b_rpm,
    input  wire logic [14:0]        i_steer_angle,
    input  wire logic               i_turn_right,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [16:0]      o_left_speed,
    output logic signed [16:0]      o_right_speed,
    output logic [19:0]             o_turn_radius,
    output logic                    o_radius_saturated,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [14:0]        i_cfg_data
);
    import dtws_pkg::*;

    localparam int NW_R = 41 + SPEED_FRAC_BITS + 2;
    localparam int DW_R = 32;
    localparam int NW_T = 59;
    localparam int DW_T = 43;
    localparam int PRW  = 36;

    logic        en;
    logic [9:0]  r_car_len, r_track_mm;
    logic [14:0] r_max_ang;

    t_side                front_side, cor_side;
    logic signed [ZW-1:0] front_z;
    logic signed [XW-1:0] cor_x, cor_y;

    logic [40:0] r_p_lx, r_p_wy;
    logic [30:0] r_p_y;
    t_ctl        r_p_ctl;
    t_ctl        r_c [0:DIV_QW];

    logic [NW_R-1:0]   div_nr;
    logic [DW_R-1:0]   div_dr;
    logic [NW_T-1:0]   div_nt;
    logic [DW_T-1:0]   div_dt;
    logic [DIV_QW-1:0] q_r, q_t;
    logic              ovf_r, ovf_t;

    logic        r_f1_vld, r_f1_right, r_f1_sat;
    logic [19:0] r_f1_radius;
    logic [16:0] r_f1_ratio;
    logic signed [BASE_W-1:0] r_f1_base;
    logic [19:0] n_radius;
    logic [16:0] n_ratio;
    logic        n_sat;

    logic        r_f2_vld, r_f2_right, r_f2_sat;
    logic [19:0] r_f2_radius;
    logic signed [PRW-1:0] r_f2_in, r_f2_out;

    logic        r_o_vld;
    logic signed [16:0] s_in, s_out;

    function automatic logic signed [16:0] round_sat(input logic signed [PRW-1:0] p);
        logic [PRW-1:0] mag;
        logic [PRW-1:0] r;
        logic signed [16:0] v;
        begin
            mag = p[PRW-1] ? PRW'(-p) : PRW'(p);
            r   = (mag + (PRW'(1) << 15)) >> 16;
            if (p[PRW-1]) v = (r > PRW'(65536)) ? 17'sh10000 : -$signed(r[16:0]);
            else          v = (r > PRW'(65535)) ? 17'sh0FFFF : $signed(r[16:0]);
            return v;
        end
    endfunction

    assign en          = !r_o_vld || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_len  <= 10'd135;
            r_track_mm <= 10'd180;
            r_max_ang  <= 15'd17157;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CAR_LENGTH:  r_car_len  <= i_cfg_data[9:0];
                CFG_TRACK_WIDTH: r_track_mm <= i_cfg_data[9:0];
                CFG_MAX_STEER:   r_max_ang  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dtws_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (i_valid),
        .i_a       (i_motor_a_rpm),
        .i_b       (i_motor_b_rpm),
        .i_ang     (i_steer_angle),
        .i_right   (i_turn_right),
        .i_max_ang (r_max_ang),
        .o_side    (front_side),
        .o_z       (front_z)
    );

    dtws_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_z     (front_z),
        .i_side  (front_side),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_side  (cor_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl.vld <= 1'b0;
        end else if (en) begin
            r_p_lx  <= 41'(r_car_len * cor_x[30:0]);
            r_p_wy  <= 41'(r_track_mm * cor_y[30:0]);
            r_p_y   <= cor_y[30:0];
            r_p_ctl <= '{vld: cor_side.vld, right: cor_side.right, base: cor_side.base,
                         ysat: cor_y[XW-1] || cor_y == '0,
                         xz: cor_x[XW-1] || cor_x == '0 || r_car_len == '0};
        end
    end

    assign div_nr = (NW_R'(r_p_lx) << (SPEED_FRAC_BITS + 1)) + NW_R'(r_p_y);
    assign div_dr = {r_p_y, 1'b0};
    assign div_nt = (NW_T'(r_p_wy) << 17) + (NW_T'(r_p_lx) << 1);
    assign div_dt = {r_p_lx, 2'b00};

    dtws_div #(.NW(NW_R), .DW(DW_R), .QW(DIV_QW)) u_div_radius (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (div_nr),
        .i_d   (div_dr),
        .o_q   (q_r),
        .o_ovf (ovf_r)
    );

    dtws_div #(.NW(NW_T), .DW(DW_T), .QW(DIV_QW)) u_div_ratio (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (div_nt),
        .i_d   (div_dt),
        .o_q   (q_t),
        .o_ovf (ovf_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_QW; k++) r_c[k].vld <= 1'b0;
        end else if (en) begin
            r_c[0] <= r_p_ctl;
            for (int k = 1; k <= DIV_QW; k++) r_c[k] <= r_c[k-1];
        end
    end

    always_comb begin
        priority if (r_c[DIV_QW].ysat) begin
            n_radius = RADIUS_MAX;
            n_sat    = 1'b1;
            n_ratio  = '0;
        end else if (r_c[DIV_QW].xz) begin
            n_radius = '0;
            n_sat    = 1'b0;
            n_ratio  = RATIO_ONE;
        end else begin
            n_sat    = ovf_r || q_r > DIV_QW'(RADIUS_MAX);
            n_radius = n_sat ? RADIUS_MAX : q_r[19:0];
            n_ratio  = (ovf_t || q_t > DIV_QW'(RATIO_ONE)) ? RATIO_ONE : q_t[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (en) begin
            r_f1_vld <= r_c[DIV_QW].vld;
            r_f2_vld <= r_f1_vld;
            r_o_vld  <= r_f2_vld;
        end
        if (en) begin
            r_f1_right  <= r_c[DIV_QW].right;
            r_f1_base   <= r_c[DIV_QW].base;
            r_f1_radius <= n_radius;
            r_f1_sat    <= n_sat;
            r_f1_ratio  <= n_ratio;
            r_f2_in     <= PRW'(r_f1_base * $signed(19'(RATIO_ONE - r_f1_ratio)));
            r_f2_out    <= PRW'(r_f1_base * $signed(19'(RATIO_ONE + r_f1_ratio)));
            r_f2_right  <= r_f1_right;
            r_f2_radius <= r_f1_radius;
            r_f2_sat    <= r_f1_sat;
            o_left_speed       <= r_f2_right ? s_out : s_in;
            o_right_speed      <= r_f2_right ? s_in : s_out;
            o_turn_radius      <= r_f2_radius;
            o_radius_saturated <= r_f2_sat;
        end
    end

    assign s_in    = round_sat(r_f2_in);
    assign s_out   = round_sat(r_f2_out);
    assign o_valid = r_o_vld;

`ifndef SYNTHESIS
    a_sat_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_radius_saturated |-> o_turn_radius == RADIUS_MAX)
        else $error("saturated radius not at maximum");
    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_turn_radius == '0 |-> !o_radius_saturated)
        else $error("zero radius flagged saturated");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while output stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_left_speed) && $stable(o_turn_radius))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
